@@ hw/rtl/dtr_pkg.sv @@
// Shared types, constants and numeral tables for the decimal to roman numeral block.
package dtr_pkg;

    localparam logic signed [15:0] NUM_LOW  = 16'sd1000;
    localparam logic signed [15:0] NUM_HIGH = 16'sd3000;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [7:0] ASCII_NONE = 8'h00;
    localparam logic [7:0] ASCII_M    = 8'h4D;
    localparam logic [7:0] ASCII_D    = 8'h44;
    localparam logic [7:0] ASCII_C    = 8'h43;
    localparam logic [7:0] ASCII_L    = 8'h4C;
    localparam logic [7:0] ASCII_X    = 8'h58;
    localparam logic [7:0] ASCII_V    = 8'h56;
    localparam logic [7:0] ASCII_I    = 8'h49;

    // Decimal places in emit order
    typedef enum logic [1:0] {
        PLACE_THOUSANDS,
        PLACE_HUNDREDS,
        PLACE_TENS,
        PLACE_UNITS
    } place_t;

    // Which letter of a place: one, five or ten
    typedef enum logic [1:0] {
        SEL_ONE,
        SEL_FIVE,
        SEL_TEN
    } sel_t;

    // One classified request as it waits in the queue
    typedef struct packed {
        logic       oor;
        logic [1:0] thousands;
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] units;
    } digits_t;

    // Queue status seen by the back end
    typedef struct packed {
        logic    not_empty;
        digits_t head;
    } queue_head_t;

    // Number of letters a decimal digit takes
    function automatic logic [2:0] shape_len(input logic [3:0] digit);
        logic [2:0] len;
        begin
            case (digit)
                4'd0:    len = 3'd0;
                4'd1:    len = 3'd1;
                4'd2:    len = 3'd2;
                4'd3:    len = 3'd3;
                4'd4:    len = 3'd2;
                4'd5:    len = 3'd1;
                4'd6:    len = 3'd2;
                4'd7:    len = 3'd3;
                4'd8:    len = 3'd4;
                4'd9:    len = 3'd2;
                default: len = 3'd0;
            endcase
            return len;
        end
    endfunction

    // Letter choice at position idx of a digit's pattern
    function automatic sel_t shape_sel(input logic [3:0] digit, input logic [1:0] idx);
        sel_t sel;
        begin
            sel = SEL_ONE;
            case (digit)
                4'd4:    sel = (idx == 2'd0) ? SEL_ONE : SEL_FIVE;
                4'd5:    sel = SEL_FIVE;
                4'd6,
                4'd7,
                4'd8:    sel = (idx == 2'd0) ? SEL_FIVE : SEL_ONE;
                4'd9:    sel = (idx == 2'd0) ? SEL_ONE : SEL_TEN;
                default: sel = SEL_ONE;
            endcase
            return sel;
        end
    endfunction

    function automatic logic [7:0] place_letter(input place_t place, input sel_t sel);
        logic [7:0] ch;
        begin
            ch = ASCII_NONE;
            case (place)
                PLACE_THOUSANDS: ch = ASCII_M;
                PLACE_HUNDREDS:
                    case (sel)
                        SEL_ONE:  ch = ASCII_C;
                        SEL_FIVE: ch = ASCII_D;
                        SEL_TEN:  ch = ASCII_M;
                        default:  ch = ASCII_NONE;
                    endcase
                PLACE_TENS:
                    case (sel)
                        SEL_ONE:  ch = ASCII_X;
                        SEL_FIVE: ch = ASCII_L;
                        SEL_TEN:  ch = ASCII_C;
                        default:  ch = ASCII_NONE;
                    endcase
                PLACE_UNITS:
                    case (sel)
                        SEL_ONE:  ch = ASCII_I;
                        SEL_FIVE: ch = ASCII_V;
                        SEL_TEN:  ch = ASCII_X;
                        default:  ch = ASCII_NONE;
                    endcase
                default: ch = ASCII_NONE;
            endcase
            return ch;
        end
    endfunction

endpackage

@@ hw/rtl/decimal_to_roman_numeral.sv @@
// Top level of the decimal to roman numeral converter.
//
//  channel  valid         stall         payload
//  -------  ------------  ------------  -----------------------------------------
//  input    number_valid  number_stall  number_in
//  output   roman_valid   roman_stall   roman_char, out_of_range, last_char
//
// A request yields 1 to 14 letters, sent one letter per cycle while the output is
// not stalled; the single letter-emitting sequencer sets the rate. The first
// letter of a request passes through the queue and then the output register. A
// two-entry queue lets the front keep taking requests while the back end works or
// the output is stalled. Reset empties the queue and the output register. A stalled output holds its letter.
module decimal_to_roman_numeral (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               number_valid,
    output logic               number_stall,
    input  logic signed [15:0] number_in,
    output logic               roman_valid,
    input  logic               roman_stall,
    output logic [7:0]         roman_char,
    output logic               out_of_range,
    output logic               last_char
);

    logic                 push;
    logic                 pop;
    logic                 queue_full;
    dtr_pkg::digits_t     push_data;
    dtr_pkg::queue_head_t head;

    dtr_front u_front (
        .number_valid (number_valid),
        .number_in    (number_in),
        .queue_full   (queue_full),
        .number_stall (number_stall),
        .push         (push),
        .push_data    (push_data)
    );

    dtr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .full      (queue_full),
        .head      (head)
    );

    dtr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head         (head),
        .pop          (pop),
        .roman_valid  (roman_valid),
        .roman_stall  (roman_stall),
        .roman_char   (roman_char),
        .out_of_range (out_of_range),
        .last_char    (last_char)
    );

endmodule

@@ hw/rtl/dtr_front.sv @@
// Front end: range check and decimal digit split of each request.
module dtr_front (
    input  logic               number_valid,
    input  logic signed [15:0] number_in,
    input  logic               queue_full,
    output logic               number_stall,
    output logic               push,
    output dtr_pkg::digits_t   push_data
);

    logic        oor;
    logic [11:0] v;
    logic [1:0]  th;
    logic [11:0] th_base;
    logic [9:0]  rem_h;
    logic [3:0]  hun;
    logic [6:0]  rem_t;
    logic [3:0]  ten;
    logic [3:0]  unit;

    assign oor = (number_in < dtr_pkg::NUM_LOW) || (number_in > dtr_pkg::NUM_HIGH);
    assign v   = number_in[11:0];

    always_comb
    begin
        if (v >= 12'd3000)
        begin
            th      = 2'd3;
            th_base = 12'd3000;
        end
        else if (v >= 12'd2000)
        begin
            th      = 2'd2;
            th_base = 12'd2000;
        end
        else
        begin
            th      = 2'd1;
            th_base = 12'd1000;
        end
    end

    // remainder below 1000 for any in-range value
    assign rem_h = 10'(v - th_base);

    // digit by threshold count: thresholds are monotone, so the count is the digit
    always_comb
    begin
        hun = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_h >= 10'(k * 100))
            begin
                hun = 4'(k);
            end
        end
    end

    assign rem_t = 7'(rem_h - 10'(hun) * 10'd100);

    always_comb
    begin
        ten = 4'd0;
        for (int k = 1; k < 10; k++)
        begin
            if (rem_t >= 7'(k * 10))
            begin
                ten = 4'(k);
            end
        end
    end

    assign unit = 4'(rem_t - 7'(ten) * 7'd10);

    assign number_stall = queue_full;
    assign push         = number_valid && !queue_full;

    always_comb
    begin
        push_data.oor       = oor;
        push_data.thousands = th;
        push_data.hundreds  = hun;
        push_data.tens      = ten;
        push_data.units     = unit;
    end

endmodule

@@ hw/rtl/dtr_queue.sv @@
// Two-entry queue of classified requests between front and back ends.
module dtr_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  dtr_pkg::digits_t     push_data,
    input  logic                 pop,
    output logic                 full,
    output dtr_pkg::queue_head_t head
);

    localparam int PTR_W = $clog2(dtr_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(dtr_pkg::QUEUE_DEPTH + 1);

    dtr_pkg::digits_t entry_reg [dtr_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full           = (count_reg == CNT_W'(dtr_pkg::QUEUE_DEPTH));
    assign head.not_empty = (count_reg != '0);
    assign head.head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? PTR_W'(wr_ptr_reg + 1'b1) : wr_ptr_reg;
        rd_ptr_next = pop ? PTR_W'(rd_ptr_reg + 1'b1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = CNT_W'(count_reg + 1'b1);
        end
        else if (pop && !push)
        begin
            count_next = CNT_W'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/dtr_back.sv @@
// Back end: walks the digits of the head request and emits one letter per cycle unless the output is stalled.
module dtr_back (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dtr_pkg::queue_head_t head,
    output logic                 pop,
    output logic                 roman_valid,
    input  logic                 roman_stall,
    output logic [7:0]           roman_char,
    output logic                 out_of_range,
    output logic                 last_char
);

    logic [1:0]      place_reg, place_next;
    logic [1:0]      idx_reg, idx_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      char_reg;
    logic            oor_reg;
    logic            last_reg;

    logic [2:0]      lens [4];
    logic [3:0]      digits [4];
    logic [1:0]      eff;
    logic            more_after;
    logic            end_of_digit;
    logic            is_last;
    logic            emit;
    dtr_pkg::sel_t   sel;
    logic [7:0]      ch;

    always_comb
    begin
        digits[0] = {2'b00, head.head.thousands};
        digits[1] = head.head.hundreds;
        digits[2] = head.head.tens;
        digits[3] = head.head.units;
        lens[0]   = {1'b0, head.head.thousands};
        lens[1]   = dtr_pkg::shape_len(head.head.hundreds);
        lens[2]   = dtr_pkg::shape_len(head.head.tens);
        lens[3]   = dtr_pkg::shape_len(head.head.units);
    end

    // skip places whose digit gives no letters
    always_comb
    begin
        logic found;
        found      = 1'b0;
        eff        = place_reg;
        more_after = 1'b0;
        for (int p = 0; p < 4; p++)
        begin
            if (!found && (2'(p) >= place_reg) && (lens[p] != 3'd0))
            begin
                eff   = 2'(p);
                found = 1'b1;
            end
            else if (found && (lens[p] != 3'd0))
            begin
                more_after = 1'b1;
            end
        end
    end

    assign end_of_digit = (3'({1'b0, idx_reg} + 3'd1) >= lens[eff]);
    assign is_last      = head.head.oor || (end_of_digit && !more_after);

    always_comb
    begin
        if (eff == 2'(dtr_pkg::PLACE_THOUSANDS))
        begin
            sel = dtr_pkg::SEL_ONE;
        end
        else
        begin
            sel = dtr_pkg::shape_sel(digits[eff], idx_reg);
        end
        ch = head.head.oor ? dtr_pkg::ASCII_NONE
                           : dtr_pkg::place_letter(dtr_pkg::place_t'(eff), sel);
    end

    assign emit = head.not_empty && (!out_valid_reg || !roman_stall);
    assign pop  = emit && is_last;

    always_comb
    begin
        place_next     = place_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg && roman_stall;
        if (emit)
        begin
            out_valid_next = 1'b1;
            if (is_last)
            begin
                place_next = 2'(dtr_pkg::PLACE_THOUSANDS);
                idx_next   = 2'd0;
            end
            else if (end_of_digit)
            begin
                place_next = 2'(eff + 2'd1);
                idx_next   = 2'd0;
            end
            else
            begin
                place_next = eff;
                idx_next   = 2'(idx_reg + 2'd1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            place_reg     <= 2'(dtr_pkg::PLACE_THOUSANDS);
            idx_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            place_reg     <= place_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            char_reg <= ch;
            oor_reg  <= head.head.oor;
            last_reg <= is_last;
        end
    end

    assign roman_valid  = out_valid_reg;
    assign roman_char   = char_reg;
    assign out_of_range = oor_reg;
    assign last_char    = last_reg;

endmodule

@@ test/tb_decimal_to_roman_numeral.sv @@
// Self-checking testbench for the decimal to roman numeral converter.
`timescale 1ns / 100ps

module tb_decimal_to_roman_numeral;

    localparam int CLK_HALF_NS      = 4;
    localparam int LONG_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES     = 40;
    localparam int MAX_REPORTS      = 10;
    localparam int DIRECTED_COUNT   = 24;
    localparam int TEXT_BYTES       = 14;

    // One letter of a numeral as it leaves the block
    typedef struct {
        logic [7:0] ch;
        logic       oor;
        logic       last_flag;
    } roman_letter_t;

    // Directed row: numeral text typed in, or zero text with typed set for a reject
    typedef struct packed {
        logic signed [15:0]        number;
        logic                      typed;
        logic [8*TEXT_BYTES-1:0]   numeral;
    } numeral_case_t;

    localparam numeral_case_t DIRECTED_CASES [0:DIRECTED_COUNT-1] = '{
        '{16'sh8000,   1'b1, '0},
        '{-16'sd1,     1'b1, '0},
        '{16'sd0,      1'b1, '0},
        '{16'sd999,    1'b1, '0},
        '{16'sd1000,   1'b1, "M"},
        '{16'sd1001,   1'b1, "MI"},
        '{16'sd3000,   1'b1, "MMM"},
        '{16'sd3001,   1'b1, '0},
        '{16'sd32767,  1'b1, '0},
        '{16'sd2888,   1'b1, "MMDCCCLXXXVIII"},
        '{16'sd1444,   1'b0, '0},
        '{16'sd1999,   1'b0, '0},
        '{16'sd1494,   1'b0, '0},
        '{16'sd2949,   1'b0, '0},
        '{16'sd1555,   1'b0, '0},
        '{16'sd1666,   1'b0, '0},
        '{16'sd1777,   1'b0, '0},
        '{16'sd1010,   1'b0, '0},
        '{16'sd1100,   1'b0, '0},
        '{16'sd2004,   1'b0, '0},
        '{16'sd2090,   1'b0, '0},
        '{16'sd2400,   1'b0, '0},
        '{16'sd1234,   1'b0, '0},
        '{-16'sd21846, 1'b1, '0}
    };

    logic               clk;
    logic               rst_n;
    logic               number_valid;
    logic               number_stall;
    logic signed [15:0] number_in;
    logic               roman_valid;
    logic               roman_stall;
    logic [7:0]         roman_char;
    logic               out_of_range;
    logic               last_char;

    roman_letter_t roman_expected [$];

    int  mismatch_count;
    int  letters_checked;
    int  numbers_sent;
    int  numerals_sent;
    int  rejects_sent;
    bit  in_idle_en;
    bit  out_idle_en;
    bit  hold_request;

    decimal_to_roman_numeral u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .number_in    (number_in),
        .roman_valid  (roman_valid),
        .roman_stall  (roman_stall),
        .roman_char   (roman_char),
        .out_of_range (out_of_range),
        .last_char    (last_char)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #CLK_HALF_NS clk = ~clk;

    function automatic void push_letter(input logic [7:0] ch);
        roman_expected.push_back('{ch: ch, oor: 1'b0, last_flag: 1'b0});
    endfunction

    function automatic void push_reject();
        roman_expected.push_back('{ch: dtr_pkg::ASCII_NONE, oor: 1'b1, last_flag: 1'b1});
        rejects_sent++;
    endfunction

    // Expected letters for one request, appended to the expectation queue
    function automatic void predict_numeral(input logic signed [15:0] value);
        int               v;
        int               digit;
        dtr_pkg::place_t  place;
        logic [7:0]       one_ch;
        logic [7:0]       five_ch;
        logic [7:0]       ten_ch;
        if (value < dtr_pkg::NUM_LOW || value > dtr_pkg::NUM_HIGH)
        begin
            push_reject();
            return;
        end
        v = value;
        for (int k = 0; k < v / 1000; k++)
            push_letter(dtr_pkg::ASCII_M);
        for (int p = 1; p <= 3; p++)
        begin
            place = dtr_pkg::place_t'(p);
            case (place)
                dtr_pkg::PLACE_HUNDREDS:
                begin
                    digit = (v / 100) % 10;
                    one_ch  = dtr_pkg::ASCII_C;
                    five_ch = dtr_pkg::ASCII_D;
                    ten_ch  = dtr_pkg::ASCII_M;
                end
                dtr_pkg::PLACE_TENS:
                begin
                    digit = (v / 10) % 10;
                    one_ch  = dtr_pkg::ASCII_X;
                    five_ch = dtr_pkg::ASCII_L;
                    ten_ch  = dtr_pkg::ASCII_C;
                end
                default:
                begin
                    digit = v % 10;
                    one_ch  = dtr_pkg::ASCII_I;
                    five_ch = dtr_pkg::ASCII_V;
                    ten_ch  = dtr_pkg::ASCII_X;
                end
            endcase
            // zero digit adds nothing
            case (digit)
                1, 2, 3:
                    repeat (digit) push_letter(one_ch);
                4:
                begin
                    push_letter(one_ch);
                    push_letter(five_ch);
                end
                5, 6, 7, 8:
                begin
                    push_letter(five_ch);
                    repeat (digit - 5) push_letter(one_ch);
                end
                9:
                begin
                    push_letter(one_ch);
                    push_letter(ten_ch);
                end
                default: ;
            endcase
        end
        roman_expected[roman_expected.size() - 1].last_flag = 1'b1;
        numerals_sent++;
    endfunction

    // Typed-in numeral text, right aligned; all zero means a reject
    function automatic void push_typed(input logic [8*TEXT_BYTES-1:0] text);
        logic [7:0] ch;
        if (text == '0)
        begin
            push_reject();
            return;
        end
        for (int i = TEXT_BYTES - 1; i >= 0; i--)
        begin
            ch = text[i*8 +: 8];
            if (ch != 8'h00)
                push_letter(ch);
        end
        roman_expected[roman_expected.size() - 1].last_flag = 1'b1;
        numerals_sent++;
    endfunction

    function automatic logic signed [15:0] random_number();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 16'($urandom_range(1000, 3000));
        else if (r < 80)
            return $urandom_range(0, 1) ? 16'($urandom_range(985, 1015))
                                        : 16'($urandom_range(2985, 3015));
        else
            return 16'($urandom);
    endfunction

    function automatic int pick_gap();
        int r;
        if (!in_idle_en)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 25);
    endfunction

    // Offer one request and return at the edge that takes it
    task automatic send_number(input logic signed [15:0] value);
        number_in    <= value;
        number_valid <= 1'b1;
        @(posedge clk);
        while (number_stall)
            @(posedge clk);
        numbers_sent++;
    endtask

    task automatic idle_input(input int cycles);
        if (cycles > 0)
        begin
            number_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    task automatic send_random(input int count);
        logic signed [15:0] value;
        repeat (count)
        begin
            value = random_number();
            predict_numeral(value);
            send_number(value);
            idle_input(pick_gap());
        end
    endtask

    task automatic wait_drained();
        while (roman_expected.size() != 0)
            @(posedge clk);
    endtask

    // Output side stall: random bursts, plus a long hold-off on request
    initial
    begin : output_stall_gen
        int r;
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        roman_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request && hold_left == 0)
                hold_left = LONG_HOLD_CYCLES;
            if (hold_left > 0)
            begin
                roman_stall <= 1'b1;
                hold_left--;
                if (hold_left == 0)
                    hold_request = 1'b0;
            end
            else if (stall_left > 0)
            begin
                roman_stall <= 1'b1;
                stall_left--;
            end
            else if (!out_idle_en)
                roman_stall <= 1'b0;
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 65)
                    roman_stall <= 1'b0;
                else
                begin
                    roman_stall <= 1'b1;
                    stall_left = (r < 93) ? $urandom_range(0, 2) : $urandom_range(10, 30);
                end
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        roman_letter_t exp_letter;
        if (rst_n && roman_valid && !roman_stall)
        begin
            letters_checked++;
            if (roman_expected.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: unexpected letter 8'h%02h oor=%b last=%b",
                             $realtime, roman_char, out_of_range, last_char);
            end
            else
            begin
                exp_letter = roman_expected.pop_front();
                if (roman_char !== exp_letter.ch || out_of_range !== exp_letter.oor ||
                    last_char !== exp_letter.last_flag)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: expected 8'h%02h oor=%b last=%b,",
                                  " got 8'h%02h oor=%b last=%b"},
                                 $realtime, exp_letter.ch, exp_letter.oor,
                                 exp_letter.last_flag,
                                 roman_char, out_of_range, last_char);
                end
            end
        end
    end

    initial
    begin : stimulus
        numeral_case_t row;
        mismatch_count  = 0;
        letters_checked = 0;
        numbers_sent    = 0;
        numerals_sent   = 0;
        rejects_sent    = 0;
        in_idle_en      = 1'b1;
        out_idle_en     = 1'b1;
        hold_request    = 1'b0;
        rst_n        <= 1'b0;
        number_valid <= 1'b0;
        number_in    <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_CASES[i];
            if (row.typed)
                push_typed(row.numeral);
            else
                predict_numeral(row.number);
            send_number(row.number);
            idle_input(pick_gap());
        end

        // back to back on both sides
        in_idle_en  = 1'b0;
        out_idle_en = 1'b0;
        send_random(40);

        // output held off while requests keep coming, so the input backs up
        hold_request = 1'b1;
        send_random(20);

        // sender pauses until every letter is out
        number_valid <= 1'b0;
        wait_drained();
        @(posedge clk);

        in_idle_en  = 1'b1;
        out_idle_en = 1'b1;
        send_random(86);
        number_valid <= 1'b0;

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d numbers: %0d converted, %0d rejected; %0d letters checked",
                 numbers_sent, numerals_sent, rejects_sent, letters_checked);
        $display("Covered range edges, longest numeral, subtractive forms, back-pressure");
        if (mismatch_count == 0 && roman_expected.size() == 0)
            $display("tb_decimal_to_roman_numeral OK");
        else
            $display("tb_decimal_to_roman_numeral NOT OK");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("tb_decimal_to_roman_numeral NOT OK");
        $finish;
    end

endmodule
